// ===== design/stc_pkg.sv =====
`timescale 1ns / 1ps

package stc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ALPHA_W    = 9;
    localparam int TRUNC_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int COST_W     = 16;
    localparam int DISP_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_TRUNC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_TRUNC  = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE         = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET       = 9'd128;
    localparam logic [TRUNC_W-1:0] COLOR_TRUNC_RESET = 8'd100;
    localparam logic [TRUNC_W-1:0] GRAD_TRUNC_RESET  = 8'd150;

    typedef struct packed {
        logic [CHAN_W-1:0] gradient;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    localparam int PIXEL_W = $bits(t_pixel);

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

// ===== design/stc_pix_if.sv =====
`timescale 1ns / 1ps

interface stc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_blue;
    logic [7:0] left_green;
    logic [7:0] left_red;
    logic [7:0] left_gradient;
    logic [7:0] right_blue;
    logic [7:0] right_green;
    logic [7:0] right_red;
    logic [7:0] right_gradient;
    logic       row_start;

    modport source (
        output valid, left_blue, left_green, left_red, left_gradient,
        output right_blue, right_green, right_red, right_gradient, row_start,
        input  ready
    );

    modport sink (
        input  valid, left_blue, left_green, left_red, left_gradient,
        input  right_blue, right_green, right_red, right_gradient, row_start,
        output ready
    );
endinterface

// ===== design/stc_res_if.sv =====
`timescale 1ns / 1ps

interface stc_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  disparity;
    logic [15:0] best_cost;

    modport source (
        output valid, disparity, best_cost,
        input  ready
    );

    modport sink (
        input  valid, disparity, best_cost,
        output ready
    );
endinterface

// ===== design/stc_ram.sv =====
`timescale 1ns / 1ps

module stc_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/stc_cost_unit.sv =====
`timescale 1ns / 1ps

module stc_cost_unit
    import stc_pkg::*;
#(
    parameter int DW = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stage_ctl         i_ctl,
    input  logic [DW-1:0]      i_d,
    input  t_pixel             i_left,
    input  t_pixel             i_right,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic [TRUNC_W-1:0] i_color_trunc,
    input  logic [TRUNC_W-1:0] i_grad_trunc,
    output t_stage_ctl         o_ctl,
    output logic [DW-1:0]      o_d,
    output logic [COST_W-1:0]  o_cost
);

    localparam int SAD_W  = CHAN_W + 2;
    localparam int PROD_W = ALPHA_W + TRUNC_W;

    t_stage_ctl         r_ctl_a;
    t_stage_ctl         r_ctl_b;
    logic [DW-1:0]      r_d_a;
    logic [DW-1:0]      r_d_b;
    logic [TRUNC_W-1:0] r_sad;
    logic [TRUNC_W-1:0] r_gd;
    logic [COST_W-1:0]  r_cost;

    logic [CHAN_W-1:0]  w_db;
    logic [CHAN_W-1:0]  w_dg;
    logic [CHAN_W-1:0]  w_dr;
    logic [CHAN_W-1:0]  w_dgrad;
    logic [SAD_W-1:0]   w_sad;
    logic [TRUNC_W-1:0] n_sad;
    logic [TRUNC_W-1:0] n_gd;
    logic [ALPHA_W-1:0] w_alpha;
    logic [ALPHA_W-1:0] w_grad_weight;
    logic [PROD_W-1:0]  w_sum;

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        w_db    = absdiff(i_left.blue, i_right.blue);
        w_dg    = absdiff(i_left.green, i_right.green);
        w_dr    = absdiff(i_left.red, i_right.red);
        w_dgrad = absdiff(i_left.gradient, i_right.gradient);
        w_sad   = SAD_W'(w_db) + SAD_W'(w_dg) + SAD_W'(w_dr);
        n_sad   = (w_sad > SAD_W'(i_color_trunc)) ? i_color_trunc : w_sad[TRUNC_W-1:0];
        n_gd    = (w_dgrad > i_grad_trunc) ? i_grad_trunc : w_dgrad;

        w_alpha       = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
        w_grad_weight = ALPHA_ONE - w_alpha;
        w_sum         = PROD_W'(w_alpha) * PROD_W'(r_sad)
                      + PROD_W'(w_grad_weight) * PROD_W'(r_gd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
        end else begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_a  <= i_d;
        r_sad  <= n_sad;
        r_gd   <= n_gd;
        r_d_b  <= r_d_a;
        r_cost <= w_sum[COST_W-1:0];
    end

    assign o_ctl  = r_ctl_b;
    assign o_d    = r_d_b;
    assign o_cost = r_cost;

endmodule

// ===== design/stereo_cost_winner_take_all.sv =====
`timescale 1ns / 1ps
// Each pixel pair scores disparities 0 to its column, one disparity per cycle through one
// shared cost unit, where the column is clamped to MAX_DISPARITY - 1. The next input is
// taken only once the pair's result has been loaded into the output register.
// Reset is synchronous and active low; it restores the configuration registers to their
// defaults and restarts the column count, and the block is ready in the first cycle after reset.

module stereo_cost_winner_take_all
    import stc_pkg::*;
#(
    parameter int MAX_DISPARITY = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stc_pix_if.sink               i_pix,
    stc_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int            DW   = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
    localparam logic [DW-1:0] LAST = DW'(MAX_DISPARITY - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [DW-1:0]      r_col;
    logic [DW-1:0]      r_col_run;
    logic [DW-1:0]      r_wp;
    logic [DW-1:0]      r_rd_addr;
    logic [DW-1:0]      r_rd_d;
    t_stage_ctl         r_ctl1;
    logic [DW-1:0]      r_d1;
    logic               r_out_valid;
    logic [DISP_W-1:0]  r_out_disp;
    logic [COST_W-1:0]  r_out_cost;

    logic [ALPHA_W-1:0] r_alpha;
    logic [TRUNC_W-1:0] r_color_trunc;
    logic [TRUNC_W-1:0] r_grad_trunc;

    t_pixel             r_left;
    logic [COST_W-1:0]  r_best;
    logic [DW-1:0]      r_bd;

    logic               w_accept;
    logic [DW-1:0]      w_col;
    logic [DW-1:0]      n_wp;
    logic [DW-1:0]      n_col;
    logic               w_rd_last;
    logic               w_rd_en;
    t_pixel             w_right_in;
    logic [PIXEL_W-1:0] w_rdata;
    t_stage_ctl         w_cu_ctl;
    logic [DW-1:0]      w_cu_d;
    logic [COST_W-1:0]  w_cu_cost;
    logic               w_take;
    logic               w_out_free;
    logic               w_out_load;
    logic [DW+DISP_W-1:0] w_bd_ext;

    assign i_pix.ready = (r_state == S_IDLE);
    assign w_accept    = i_pix.valid && (r_state == S_IDLE);
    assign w_rd_en     = (r_state == S_RUN);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_out_load  = (r_state == S_FINISH) && w_out_free;

    always_comb begin
        w_col      = i_pix.row_start ? '0 : r_col;
        n_col      = (w_col == LAST) ? w_col : w_col + 1'b1;
        n_wp       = (r_wp == LAST) ? '0 : r_wp + 1'b1;
        w_rd_last  = (r_rd_d == r_col_run);
        w_right_in = '{gradient: i_pix.right_gradient, red: i_pix.right_red,
                       green: i_pix.right_green, blue: i_pix.right_blue};
        w_take     = (w_cu_d == '0) || (w_cu_cost < r_best);
        w_bd_ext   = {{DISP_W{1'b0}}, r_bd};
    end

    stc_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_DISPARITY)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (n_wp),
        .i_wdata (w_right_in),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    stc_cost_unit #(
        .DW (DW)
    ) u_cost (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (r_ctl1),
        .i_d           (r_d1),
        .i_left        (r_left),
        .i_right       (t_pixel'(w_rdata)),
        .i_alpha       (r_alpha),
        .i_color_trunc (r_color_trunc),
        .i_grad_trunc  (r_grad_trunc),
        .o_ctl         (w_cu_ctl),
        .o_d           (w_cu_d),
        .o_cost        (w_cu_cost)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha       <= ALPHA_RESET;
            r_color_trunc <= COLOR_TRUNC_RESET;
            r_grad_trunc  <= GRAD_TRUNC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHA:       r_alpha       <= i_cfg_data;
                CFG_COLOR_TRUNC: r_color_trunc <= i_cfg_data[TRUNC_W-1:0];
                CFG_GRAD_TRUNC:  r_grad_trunc  <= i_cfg_data[TRUNC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left <= '{gradient: i_pix.left_gradient, red: i_pix.left_red,
                        green: i_pix.left_green, blue: i_pix.left_blue};
        end
        if (w_cu_ctl.valid && w_take) begin
            r_best <= w_cu_cost;
            r_bd   <= w_cu_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_col_run   <= '0;
            r_wp        <= '0;
            r_rd_addr   <= '0;
            r_rd_d      <= '0;
            r_ctl1      <= '0;
            r_d1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_ctl1 <= '0;
                    if (w_accept) begin
                        r_wp      <= n_wp;
                        r_rd_addr <= n_wp;
                        r_rd_d    <= '0;
                        r_col_run <= w_col;
                        r_col     <= n_col;
                        r_state   <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_ctl1    <= '{valid: 1'b1, last: w_rd_last};
                    r_d1      <= r_rd_d;
                    r_rd_d    <= r_rd_d + 1'b1;
                    r_rd_addr <= (r_rd_addr == '0) ? LAST : r_rd_addr - 1'b1;
                    if (w_rd_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_ctl1 <= '0;
                    if (w_cu_ctl.valid && w_cu_ctl.last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_disp  <= w_bd_ext[DISP_W-1:0];
                        r_out_cost  <= r_best;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.disparity = r_out_disp;
    assign o_res.best_cost = r_out_cost;

endmodule

// ===== design/stc_checker.sv =====
`timescale 1ns / 1ps

module stc_checker #(
    parameter int MAX_DISPARITY = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_disparity,
    input logic [15:0] i_best_cost
);

    // The block works on one pixel pair at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while a pixel pair is still being scored");

    // A result only appears after a pixel pair has been taken in.
    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised while no pixel pair was in flight");

    a_disparity_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_disparity) < 32'(MAX_DISPARITY)))
        else $error("disparity outside the search range");

    a_cost_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_best_cost <= 16'd65280))
        else $error("cost above the largest weighted truncated value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_disparity) && $stable(i_best_cost)))
        else $error("stalled result changed or was dropped");

endmodule

bind stereo_cost_winner_take_all stc_checker #(
    .MAX_DISPARITY (MAX_DISPARITY)
) u_stc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_disparity (o_res.disparity),
    .i_best_cost (o_res.best_cost)
);
